### hw/rtl/lgg_pkg.sv
// Shared types and constants for the Life grid generations block.
// Used by lgg_cfg, lgg_ctrl, lgg_dp and life_grid_generations; no dependencies.
package lgg_pkg;

    localparam int ROW_W   = 64;
    localparam int SIZE_W  = 7;
    localparam int GEN_W   = 16;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 3;

    localparam logic [0:0] REG_GRID_SIZE   = 1'b0;
    localparam logic [0:0] REG_GENERATIONS = 1'b1;

    localparam logic [SIZE_W-1:0] GRID_SIZE_RST   = 7'd64;
    localparam logic [GEN_W-1:0]  GENERATIONS_RST = 16'd1;

    typedef enum logic [2:0]
    {
        ST_LOAD = 3'b001,
        ST_GEN  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed
    {
        logic              load_we;
        logic [SIZE_W-1:0] load_addr;
        logic              rd_en;
        logic              emit_rd;
        logic              emit_last;
        logic [SIZE_W-1:0] rd_addr;
        logic              gen_we;
        logic [SIZE_W-1:0] wr_addr;
        logic              up_zero;
        logic              dn_zero;
        logic              flip;
        logic              cur_clear;
    } cmd_t;

    typedef struct packed
    {
        logic emit_ok;
    } status_t;

endpackage

### hw/rtl/lgg_cfg.sv
// Configuration registers (grid size, generation count) behind the APB-style port.
// Depends on lgg_pkg; produces the effective grid size clamped to 1..GRID_MAX.
module lgg_cfg #(
    parameter int GRID_MAX = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lgg_pkg::DATA_W-1:0]   pwdata,
    output logic [lgg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [lgg_pkg::SIZE_W-1:0]   size_eff,
    output logic [lgg_pkg::GEN_W-1:0]    generations
);

    logic [lgg_pkg::SIZE_W-1:0] grid_size_reg;
    logic [lgg_pkg::GEN_W-1:0]  gens_reg;
    logic                       wr_en;
    logic [0:0]                 reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= lgg_pkg::GRID_SIZE_RST;
            gens_reg      <= lgg_pkg::GENERATIONS_RST;
        end
        else if (wr_en)
        begin
            if (reg_idx == lgg_pkg::REG_GRID_SIZE)
                grid_size_reg <= pwdata[lgg_pkg::SIZE_W-1:0];
            else if (reg_idx == lgg_pkg::REG_GENERATIONS)
                gens_reg <= pwdata[lgg_pkg::GEN_W-1:0];
        end
    end

    always_comb
    begin
        case (reg_idx)
            lgg_pkg::REG_GRID_SIZE:
                prdata = {{(lgg_pkg::DATA_W-lgg_pkg::SIZE_W){1'b0}}, grid_size_reg};
            lgg_pkg::REG_GENERATIONS:
                prdata = {{(lgg_pkg::DATA_W-lgg_pkg::GEN_W){1'b0}}, gens_reg};
            default:
                prdata = '0;
        endcase
    end

    // clamp size into 1..GRID_MAX
    always_comb
    begin
        if (grid_size_reg == '0)
            size_eff = lgg_pkg::SIZE_W'(1);
        else if (grid_size_reg > lgg_pkg::SIZE_W'(GRID_MAX))
            size_eff = lgg_pkg::SIZE_W'(GRID_MAX);
        else
            size_eff = grid_size_reg;
    end

    assign generations = gens_reg;

endmodule

### hw/rtl/lgg_ctrl.sv
// Sequencer for loading, generation sweeps and emission of the grid.
// Depends on lgg_pkg; drives lgg_dp through cmd_t and reads status_t.
module lgg_ctrl #(
    parameter int GRID_MAX = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lgg_pkg::SIZE_W-1:0] size_eff,
    input  logic [lgg_pkg::GEN_W-1:0]  generations,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  lgg_pkg::status_t           status,
    output lgg_pkg::cmd_t              cmd
);

    lgg_pkg::state_t            state_reg, state_next;
    logic [lgg_pkg::SIZE_W-1:0] row_cnt_reg, row_cnt_next;
    logic [lgg_pkg::SIZE_W-1:0] step_reg, step_next;
    logic [lgg_pkg::SIZE_W-1:0] emit_cnt_reg, emit_cnt_next;
    logic [lgg_pkg::GEN_W-1:0]  gen_cnt_reg, gen_cnt_next;
    logic [lgg_pkg::SIZE_W-1:0] row_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lgg_pkg::ST_LOAD;
            row_cnt_reg  <= '0;
            step_reg     <= '0;
            emit_cnt_reg <= '0;
            gen_cnt_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            row_cnt_reg  <= row_cnt_next;
            step_reg     <= step_next;
            emit_cnt_reg <= emit_cnt_next;
            gen_cnt_reg  <= gen_cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        row_cnt_next  = row_cnt_reg;
        step_next     = step_reg;
        emit_cnt_next = emit_cnt_reg;
        gen_cnt_next  = gen_cnt_reg;
        row_sum       = row_cnt_reg;
        cmd           = '0;
        in_ready      = 1'b0;

        case (state_reg)
            lgg_pkg::ST_LOAD:
            begin
                in_ready      = 1'b1;
                cmd.load_addr = row_cnt_reg;
                if (in_valid)
                begin
                    cmd.load_we = row_cnt_reg < lgg_pkg::SIZE_W'(GRID_MAX);
                    row_sum     = cmd.load_we ? row_cnt_reg + lgg_pkg::SIZE_W'(1) : row_cnt_reg;
                    if (row_sum >= size_eff)
                    begin
                        row_cnt_next  = '0;
                        step_next     = '0;
                        gen_cnt_next  = '0;
                        emit_cnt_next = '0;
                        cmd.cur_clear = 1'b1;
                        state_next    = (generations == '0) ? lgg_pkg::ST_EMIT
                                                            : lgg_pkg::ST_GEN;
                    end
                    else
                    begin
                        row_cnt_next = row_sum;
                    end
                end
            end

            lgg_pkg::ST_GEN:
            begin
                // read row step, compute row step-2 from the three-row window
                cmd.rd_en   = step_reg < size_eff;
                cmd.rd_addr = step_reg;
                if (step_reg >= lgg_pkg::SIZE_W'(2))
                begin
                    cmd.gen_we  = 1'b1;
                    cmd.wr_addr = step_reg - lgg_pkg::SIZE_W'(2);
                    cmd.up_zero = step_reg == lgg_pkg::SIZE_W'(2);
                    cmd.dn_zero = step_reg > size_eff;
                end
                if (step_reg > size_eff)
                begin
                    cmd.flip     = 1'b1;
                    step_next    = '0;
                    gen_cnt_next = gen_cnt_reg + lgg_pkg::GEN_W'(1);
                    if (gen_cnt_next == generations)
                        state_next = lgg_pkg::ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + lgg_pkg::SIZE_W'(1);
                end
            end

            lgg_pkg::ST_EMIT:
            begin
                cmd.rd_addr = emit_cnt_reg;
                if (status.emit_ok)
                begin
                    cmd.emit_rd   = 1'b1;
                    emit_cnt_next = emit_cnt_reg + lgg_pkg::SIZE_W'(1);
                    cmd.emit_last = emit_cnt_next == size_eff;
                    if (cmd.emit_last)
                        state_next = lgg_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = lgg_pkg::ST_LOAD;
            end
        endcase
    end

endmodule

### hw/rtl/lgg_dp.sv
// Datapath: two grid banks, three-row window, Life rule and output register.
// Depends on lgg_pkg; controlled by lgg_ctrl through cmd_t.
module lgg_dp #(
    parameter int GRID_MAX = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  lgg_pkg::cmd_t              cmd,
    output lgg_pkg::status_t           status,
    input  logic [lgg_pkg::SIZE_W-1:0] size_eff,
    input  logic [lgg_pkg::ROW_W-1:0]  row_cells,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [lgg_pkg::ROW_W-1:0]  result_row,
    output logic                       last_row
);

    localparam int AW = $clog2(GRID_MAX);

    logic [lgg_pkg::ROW_W-1:0] mem0 [GRID_MAX];
    logic [lgg_pkg::ROW_W-1:0] mem1 [GRID_MAX];
    logic [lgg_pkg::ROW_W-1:0] rd0_reg, rd1_reg;
    logic [lgg_pkg::ROW_W-1:0] up_reg, mid_reg;
    logic [lgg_pkg::ROW_W-1:0] out_row_reg;
    logic                      out_last_reg, out_valid_reg;
    logic                      pend_reg, pend_last_reg;
    logic                      cur_reg;

    logic [lgg_pkg::ROW_W-1:0] mask, rdata, up, dn, life_row;
    logic [lgg_pkg::ROW_W-1:0] ones, twos, fours, c1, c2;
    logic [lgg_pkg::ROW_W-1:0] terms [8];
    logic                      rd_en;
    logic [AW-1:0]             rd_a, wr_a, ld_a;

    assign rd_en = cmd.rd_en || cmd.emit_rd;
    assign rd_a  = cmd.rd_addr[AW-1:0];
    assign wr_a  = cmd.wr_addr[AW-1:0];
    assign ld_a  = cmd.load_addr[AW-1:0];

    always_comb
    begin
        for (int c = 0; c < lgg_pkg::ROW_W; c++)
            mask[c] = c < int'(size_eff);
    end

    assign rdata = cur_reg ? rd1_reg : rd0_reg;
    assign up    = cmd.up_zero ? '0 : up_reg;
    assign dn    = cmd.dn_zero ? '0 : rdata;

    // bit-parallel neighbour count: ones/twos modulo four, fours sticky
    always_comb
    begin
        terms[0] = (up << 1) & mask;
        terms[1] = up;
        terms[2] = (up >> 1) & mask;
        terms[3] = (mid_reg << 1) & mask;
        terms[4] = (mid_reg >> 1) & mask;
        terms[5] = (dn << 1) & mask;
        terms[6] = dn;
        terms[7] = (dn >> 1) & mask;
        ones  = '0;
        twos  = '0;
        fours = '0;
        c1    = '0;
        c2    = '0;
        for (int i = 0; i < 8; i++)
        begin
            c1    = ones & terms[i];
            ones  = ones ^ terms[i];
            c2    = twos & c1;
            twos  = twos ^ c1;
            fours = fours | c2;
        end
        life_row = twos & ~fours & (ones | mid_reg) & mask;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_we)
            mem0[ld_a] <= row_cells & mask;
        else if (cmd.gen_we && cur_reg)
            mem0[wr_a] <= life_row;
        if (rd_en)
            rd0_reg <= mem0[rd_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_we && !cur_reg)
            mem1[wr_a] <= life_row;
        if (rd_en)
            rd1_reg <= mem1[rd_a];
    end

    always_ff @(posedge clk)
    begin
        up_reg        <= mid_reg;
        mid_reg       <= rdata;
        pend_last_reg <= cmd.emit_last;
        if (pend_reg)
        begin
            out_row_reg  <= rdata & mask;
            out_last_reg <= pend_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cur_clear)
                cur_reg <= 1'b0;
            else if (cmd.flip)
                cur_reg <= ~cur_reg;
            pend_reg <= cmd.emit_rd;
            if (pend_reg)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.emit_ok = !pend_reg && (!out_valid_reg || out_ready);
    assign out_valid      = out_valid_reg;
    assign result_row     = out_row_reg;
    assign last_row       = out_last_reg;

endmodule

### hw/rtl/life_grid_generations.sv
// Top level of the Life grid generations block.
// Depends on lgg_pkg, lgg_cfg, lgg_ctrl and lgg_dp.
//
// Use: write grid_size (byte address 0) and generations (byte address 4)
// over the APB-style port while the block is idle. Then send the grid on the
// input channel, one row per item (row_cells, bit c is column c). Rows load
// at one per cycle; bits at or above the grid size are dropped.
// When the last row is taken the block stops accepting input and runs the
// generations, one row per cycle through a three-row window over the current
// bank, writing the other bank.
// The final grid then leaves on the output channel, one row per item with
// last_row set on the final row. The single read port of the grid banks and
// the output register set the row rate: a row read waits until the previous row
// is in the output register; a stall on out_ready holds it there and pauses reads.
// The first result row passes the bank read register, then the output register.
// Input is taken again once the last row read is issued.
// Reset clears the sequencer (back to loading, no rows held), sets
// grid_size to 64 and generations to 1. Grid banks are not cleared.
module life_grid_generations #(
    parameter int GRID_MAX = 64
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lgg_pkg::PADDR_W-1:0]  paddr,
    input  logic [lgg_pkg::DATA_W-1:0]   pwdata,
    output logic [lgg_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [lgg_pkg::ROW_W-1:0]    row_cells,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [lgg_pkg::ROW_W-1:0]    result_row,
    output logic                         last_row
);

    logic [lgg_pkg::SIZE_W-1:0] size_eff;
    logic [lgg_pkg::GEN_W-1:0]  generations;
    lgg_pkg::cmd_t              cmd;
    lgg_pkg::status_t           status;

    lgg_cfg #(
        .GRID_MAX (GRID_MAX)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .size_eff    (size_eff),
        .generations (generations)
    );

    lgg_ctrl #(
        .GRID_MAX (GRID_MAX)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .size_eff    (size_eff),
        .generations (generations),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .status      (status),
        .cmd         (cmd)
    );

    lgg_dp #(
        .GRID_MAX (GRID_MAX)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .size_eff   (size_eff),
        .row_cells  (row_cells),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .result_row (result_row),
        .last_row   (last_row)
    );

    a_bank_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_we |-> !cmd.gen_we && !cmd.emit_rd)
        else $error("grid load collides with generation write or emission read");

    a_emit_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_rd |=> !cmd.emit_rd)
        else $error("emission reads issued back to back");

    a_flip_at_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flip |-> cmd.gen_we && cmd.dn_zero)
        else $error("bank swap outside the final row of a sweep");

    a_no_input_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.gen_we || cmd.emit_rd) |-> !in_ready)
        else $error("input taken during a sweep or emission");

endmodule

### dv/tb_top.sv
// Self-checking testbench for life_grid_generations: loads grids over the row channel,
// runs them through a bit-exact Life predictor and checks every result row and its last_row.
// Depends on lgg_pkg and the life_grid_generations RTL; needs no files or arguments.
module tb_top;
    import lgg_pkg::*;

    localparam int GRID_MAX    = 64;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 12;
    localparam int RAND_ROWS   = 410;

    typedef enum logic [2:0]
    {
        DO_ROW,
        DO_SIZE,
        DO_GENS,
        DO_READ_SIZE,
        DO_READ_GENS
    } step_kind_t;

    typedef enum int
    {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct
    {
        step_kind_t       kind;
        logic [ROW_W-1:0] val;
        bit               typed;
        logic [ROW_W-1:0] want_row;
        bit               want_last;
    } dir_step_t;

    typedef struct packed
    {
        logic [ROW_W-1:0] row;
        logic             last;
    } grid_row_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    logic [ROW_W-1:0]    row_cells = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [ROW_W-1:0]    result_row;
    logic                last_row;

    logic [ROW_W-1:0]    life_cells [GRID_MAX];
    int                  rows_held = 0;
    logic [SIZE_W-1:0]   size_reg  = GRID_SIZE_RST;
    logic [GEN_W-1:0]    gens_reg  = GENERATIONS_RST;
    grid_row_t           pending_rows [$];

    int                  idle_pct  = 0;
    int                  stall_pct = 0;
    int                  fails     = 0;
    int unsigned         ticks     = 0;

    dir_step_t plan [0:35] = '{
        '{DO_READ_SIZE, 64'h0, 1'b0, 64'd64, 1'b0},
        '{DO_READ_GENS, 64'h0, 1'b0, 64'd1, 1'b0},
        '{DO_SIZE, 64'd0, 1'b0, 64'h0, 1'b0},
        '{DO_GENS, 64'd0, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h1, 1'b1},
        '{DO_ROW, 64'h0, 1'b1, 64'h0, 1'b1},
        '{DO_ROW, 64'h8000_0000_0000_0000, 1'b1, 64'h0, 1'b1},
        '{DO_GENS, 64'd1, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0, 1'b1},
        '{DO_GENS, 64'hFFFF, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h1, 1'b1, 64'h0, 1'b1},
        '{DO_SIZE, 64'd2, 1'b0, 64'h0, 1'b0},
        '{DO_GENS, 64'd1, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
        '{DO_SIZE, 64'd3, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h2, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h2, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h2, 1'b0, 64'h0, 1'b0},
        '{DO_GENS, 64'd0, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0},
        '{DO_SIZE, 64'd2, 1'b0, 64'h0, 1'b0},
        '{DO_GENS, 64'd3, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hA5A5_A5A5_A5A5_A5A5, 1'b0, 64'h0, 1'b0},
        '{DO_SIZE, 64'd4, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h0000_0000_0000_000E, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h5A5A_5A5A_5A5A_5A5B, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0, 64'h0, 1'b0},
        '{DO_SIZE, 64'd6, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h0000_0000_0000_0007, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h0000_0000_0000_0005, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'h0000_0000_0000_003C, 1'b0, 64'h0, 1'b0},
        '{DO_SIZE, 64'd2, 1'b0, 64'h0, 1'b0},
        '{DO_ROW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0}
    };

    life_grid_generations #(.GRID_MAX(GRID_MAX)) i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        ticks <= ticks + 1;
        if (ticks >= CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int grid_span();
        int n;
        n = int'(size_reg);
        if (n == 0)
            n = 1;
        if (n > GRID_MAX)
            n = GRID_MAX;
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] row_mask(input int n);
        if (n >= ROW_W)
            return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic void evolve(input int n);
        logic [ROW_W-1:0] fresh [GRID_MAX];
        logic [ROW_W-1:0] above;
        logic [ROW_W-1:0] here;
        logic [ROW_W-1:0] below;
        int               cnt;
        int               r;
        int               c;
        for (r = 0; r < n; r++)
        begin
            above    = (r > 0) ? life_cells[r-1] : '0;
            here     = life_cells[r];
            below    = (r + 1 < n) ? life_cells[r+1] : '0;
            fresh[r] = '0;
            for (c = 0; c < n; c++)
            begin
                cnt = above[c] + below[c];
                if (c > 0)
                    cnt = cnt + above[c-1] + here[c-1] + below[c-1];
                if (c < ROW_W - 1)
                    cnt = cnt + above[c+1] + here[c+1] + below[c+1];
                fresh[r][c] = (cnt == 3) || (cnt == 2 && here[c]);
            end
        end
        for (r = 0; r < n; r++)
            life_cells[r] = fresh[r];
    endfunction

    function automatic void absorb_row(input logic [ROW_W-1:0] cells_in);
        int n;
        int r;
        n = grid_span();
        if (rows_held < GRID_MAX)
        begin
            life_cells[rows_held] = cells_in & row_mask(n);
            rows_held++;
        end
        if (rows_held < n)
            return;
        repeat (gens_reg)
            evolve(n);
        for (r = 0; r < n; r++)
            pending_rows.push_back('{row: life_cells[r] & row_mask(n), last: (r == n - 1)});
        rows_held = 0;
    endfunction

    function automatic logic [ROW_W-1:0] sample_cells();
        logic [ROW_W-1:0] a;
        logic [ROW_W-1:0] b;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: return a & b;
            1: return a | b;
            2: return 64'd1 << $urandom_range(0, ROW_W - 1);
            3: return ($urandom_range(0, 1) == 0) ? '1 : '0;
            default: return a;
        endcase
    endfunction

    task automatic set_pace(input pace_t mode);
        idle_pct  = (mode == PACE_SEND_IDLE) ? 82 : (mode == PACE_BOTH) ? 8 : 0;
        stall_pct = (mode == PACE_RECV_STALL) ? 82 : (mode == PACE_BOTH) ? 8 : 0;
    endtask

    task automatic offer_row(input logic [ROW_W-1:0] cells_in);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_cells <= cells_in;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        absorb_row(cells_in);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        wait (pending_rows.size() == 0);
        repeat (SETTLE)
            @(posedge clk);
    endtask

    task automatic check_reg(input logic [0:0] sel, input logic [DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {sel, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t: register %0d expected %h got %h", $time, sel, want, prdata);
            fails++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_reg(input logic [0:0] sel, input logic [GEN_W-1:0] value);
        logic [DATA_W-1:0] word;
        logic [DATA_W-1:0] want;
        wait_idle();
        word = $urandom;
        if (sel == REG_GRID_SIZE)
        begin
            word[SIZE_W-1:0] = value[SIZE_W-1:0];
            want = {{(DATA_W - SIZE_W){1'b0}}, value[SIZE_W-1:0]};
        end
        else
        begin
            word[GEN_W-1:0] = value;
            want = {{(DATA_W - GEN_W){1'b0}}, value};
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (sel == REG_GRID_SIZE)
            size_reg = word[SIZE_W-1:0];
        else
            gens_reg = word[GEN_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        check_reg(sel, want);
    endtask

    always @(posedge clk)
    begin : result_check
        grid_row_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                $display("%0t: result row %h last %b with nothing expected", $time,
                         result_row, last_row);
                fails++;
            end
            else
            begin
                want = pending_rows.pop_front();
                if (result_row !== want.row)
                begin
                    $display("%0t: result_row expected %h got %h", $time, want.row, result_row);
                    fails++;
                end
                if (last_row !== want.last)
                begin
                    $display("%0t: last_row expected %b got %b", $time, want.last, last_row);
                    fails++;
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    initial
    begin : stimulus
        int                fed;
        int                phase_no;
        int                n;
        int                grids;
        int                rows;
        int                g;
        logic [SIZE_W-1:0] size_raw;
        logic [GEN_W-1:0]  gen_raw;

        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_pace(PACE_BOTH);
        foreach (plan[i])
        begin
            case (plan[i].kind)
                DO_SIZE:      program_reg(REG_GRID_SIZE, plan[i].val[GEN_W-1:0]);
                DO_GENS:      program_reg(REG_GENERATIONS, plan[i].val[GEN_W-1:0]);
                DO_READ_SIZE: check_reg(REG_GRID_SIZE, plan[i].want_row[DATA_W-1:0]);
                DO_READ_GENS: check_reg(REG_GENERATIONS, plan[i].want_row[DATA_W-1:0]);
                default:
                begin
                    offer_row(plan[i].val);
                    if (plan[i].typed)
                        pending_rows[pending_rows.size() - 1] =
                            '{row: plan[i].want_row, last: plan[i].want_last};
                end
            endcase
        end

        fed      = 0;
        phase_no = 0;
        while (fed < RAND_ROWS)
        begin
            set_pace(pace_t'(phase_no % 4));
            case ($urandom_range(0, 11))
                0:       size_raw = 7'd64;
                1:       size_raw = SIZE_W'($urandom_range(65, 127));
                2:       size_raw = 7'd0;
                3:       size_raw = SIZE_W'($urandom_range(13, 63));
                default: size_raw = SIZE_W'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       gen_raw = '0;
                1:       gen_raw = GEN_W'($urandom_range(20, 60));
                default: gen_raw = GEN_W'($urandom_range(1, 4));
            endcase
            program_reg(REG_GRID_SIZE, {{(GEN_W - SIZE_W){1'b0}}, size_raw});
            program_reg(REG_GENERATIONS, gen_raw);
            n     = grid_span();
            grids = $urandom_range(1, 3);
            for (g = 0; g < grids; g++)
            begin
                if ($urandom_range(0, 5) == 0)
                    wait_idle();
                rows = n;
                if (g == grids - 1 && n > 1 && $urandom_range(0, 7) == 0)
                    rows = $urandom_range(1, n - 1);
                repeat (rows)
                    offer_row(sample_cells());
                fed += rows;
            end
            phase_no++;
        end

        wait_idle();
        if (fails == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/lgg_pkg.sv
hw/rtl/lgg_cfg.sv
hw/rtl/lgg_ctrl.sv
hw/rtl/lgg_dp.sv
hw/rtl/life_grid_generations.sv
dv/tb_top.sv
